[src/cpli_pkg.sv]
// Shared types and constants for the curve point lookup and interpolation unit.
`default_nettype none

package cpli_pkg;

   localparam int PARAM_W = 17;   // curve parameter, unsigned Q1.16
   localparam int COORD_W = 32;   // coordinate, signed Q16.16
   localparam int CFG_W   = 7;    // point count register
   localparam int INDEX_W = 6;    // entry index field of a load

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_FIRST  = 2'd1,
      STATUS_LAST   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [PARAM_W-1:0] param;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } entry_type;

   // Start command shared by both interpolation lanes.
   typedef struct packed {
      logic               start;
      logic [PARAM_W-1:0] dt;
      logic [PARAM_W-1:0] span;
   } lane_ctl_type;

endpackage

`default_nettype wire

[src/cpli_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module cpli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/cpli_lane.sv]
// Bit-serial interpolation lane: a + (b-a)*dt/span, quotient truncated toward zero.
`default_nettype none

module cpli_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cpli_pkg::lane_ctl_type        ctl,
   input  wire logic [cpli_pkg::COORD_W-1:0]  coord_a,
   input  wire logic [cpli_pkg::COORD_W-1:0]  coord_b,
   output logic      [cpli_pkg::COORD_W-1:0]  result,
   output logic                               done
);

   localparam int CW    = cpli_pkg::COORD_W;
   localparam int PW    = cpli_pkg::PARAM_W;
   localparam int SW    = PW + 2;
   localparam int CNT_W = $clog2(CW + 1);

   typedef enum logic [1:0] {L_IDLE, L_SUB, L_DIV, L_ADD} lane_state_type;

   lane_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW:0]      a_sh_ff, a_sh_in, b_sh_ff, b_sh_in;
   logic [CW:0]      pos_sh_ff, pos_sh_in, neg_sh_ff, neg_sh_in;
   logic             cp_ff, cp_in, cn_ff, cn_in, sign_ff, sign_in;
   logic [PW-1:0]    dt_ff, dt_in, span_ff, span_in, rem_ff, rem_in;
   logic [CW-1:0]    qa_ff, qa_in, qc_ff, qc_in, y0_sh_ff, y0_sh_in;
   logic             c1_ff, c1_in, c2_ff, c2_in;
   logic [CW-1:0]    res_ff, res_in;
   logic             done_ff, done_in;

   // subtract step: b-a and a-b side by side, LSB first
   logic ab, bb, p_bit, n_bit, cp_nx, cn_nx;
   // divide step
   logic          m_bit;
   logic [SW-1:0] s_val, span1, span2;
   logic [1:0]    digit;
   logic [PW-1:0] rem_nx;
   // final add step
   logic qb, qx, r_bit, c1_nx, c2_nx;

   always_comb begin
      ab    = a_sh_ff[0];
      bb    = b_sh_ff[0];
      p_bit = bb ^ ~ab ^ cp_ff;
      cp_nx = (bb & ~ab) | (bb & cp_ff) | (~ab & cp_ff);
      n_bit = ab ^ ~bb ^ cn_ff;
      cn_nx = (ab & ~bb) | (ab & cn_ff) | (~bb & cn_ff);

      // magnitude of b-a, MSB first; remainder stays below span, dt <= span
      m_bit = sign_ff ? neg_sh_ff[CW] : pos_sh_ff[CW];
      s_val = {1'b0, rem_ff, 1'b0} + (m_bit ? SW'(dt_ff) : SW'(0));
      span1 = SW'(span_ff);
      span2 = {1'b0, span_ff, 1'b0};
      if (s_val >= span2) begin
         digit  = 2'd2;
         rem_nx = PW'(s_val - span2);
      end else if (s_val >= span1) begin
         digit  = 2'd1;
         rem_nx = PW'(s_val - span1);
      end else begin
         digit  = 2'd0;
         rem_nx = PW'(s_val);
      end

      // quotient kept as qa + qc, summed serially and added to or taken from a
      qb    = qa_ff[0] ^ qc_ff[0] ^ c1_ff;
      c1_nx = (qa_ff[0] & qc_ff[0]) | (qa_ff[0] & c1_ff) | (qc_ff[0] & c1_ff);
      qx    = qb ^ sign_ff;
      r_bit = y0_sh_ff[0] ^ qx ^ c2_ff;
      c2_nx = (y0_sh_ff[0] & qx) | (y0_sh_ff[0] & c2_ff) | (qx & c2_ff);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      a_sh_in   = a_sh_ff;
      b_sh_in   = b_sh_ff;
      pos_sh_in = pos_sh_ff;
      neg_sh_in = neg_sh_ff;
      cp_in     = cp_ff;
      cn_in     = cn_ff;
      sign_in   = sign_ff;
      dt_in     = dt_ff;
      span_in   = span_ff;
      rem_in    = rem_ff;
      qa_in     = qa_ff;
      qc_in     = qc_ff;
      y0_sh_in  = y0_sh_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (ctl.start) begin
               a_sh_in  = {coord_a[CW-1], coord_a};
               b_sh_in  = {coord_b[CW-1], coord_b};
               y0_sh_in = coord_a;
               dt_in    = ctl.dt;
               span_in  = ctl.span;
               cp_in    = 1'b1;
               cn_in    = 1'b1;
               cnt_in   = '0;
               state_in = L_SUB;
            end
         end
         L_SUB: begin
            a_sh_in   = a_sh_ff >> 1;
            b_sh_in   = b_sh_ff >> 1;
            pos_sh_in = {p_bit, pos_sh_ff[CW:1]};
            neg_sh_in = {n_bit, neg_sh_ff[CW:1]};
            cp_in     = cp_nx;
            cn_in     = cn_nx;
            if (cnt_ff == CNT_W'(CW)) begin
               sign_in  = p_bit;
               cnt_in   = '0;
               rem_in   = '0;
               qa_in    = '0;
               qc_in    = '0;
               state_in = L_DIV;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         L_DIV: begin
            pos_sh_in = pos_sh_ff << 1;
            neg_sh_in = neg_sh_ff << 1;
            rem_in    = rem_nx;
            qa_in     = {qa_ff[CW-2:0], digit[0]};
            qc_in     = {qc_ff[CW-2:1], digit[1], 1'b0};
            if (cnt_ff == CNT_W'(CW)) begin
               cnt_in   = '0;
               c1_in    = 1'b0;
               c2_in    = sign_ff;
               state_in = L_ADD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         L_ADD: begin
            qa_in    = qa_ff >> 1;
            qc_in    = qc_ff >> 1;
            y0_sh_in = y0_sh_ff >> 1;
            res_in   = {r_bit, res_ff[CW-1:1]};
            c1_in    = c1_nx;
            c2_in    = c2_nx;
            if (cnt_ff == CNT_W'(CW - 1)) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_sh_ff   <= a_sh_in;
      b_sh_ff   <= b_sh_in;
      pos_sh_ff <= pos_sh_in;
      neg_sh_ff <= neg_sh_in;
      cp_ff     <= cp_in;
      cn_ff     <= cn_in;
      sign_ff   <= sign_in;
      dt_ff     <= dt_in;
      span_ff   <= span_in;
      rem_ff    <= rem_in;
      qa_ff     <= qa_in;
      qc_ff     <= qc_in;
      y0_sh_ff  <= y0_sh_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      res_ff    <= res_in;
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

[src/curve_param_lookup_interp_unit.sv]
// Top level of the curve point lookup and piecewise linear interpolation unit.
//
// The unit keeps a table of TABLE_DEPTH curve points, each an unsigned Q1.16
// parameter with a signed Q16.16 (x, y). A load request (command 0) writes one
// entry and gives no response; an entry index at or beyond TABLE_DEPTH is
// dropped. A query request (command 1) binary-searches the first point_count
// entries for the last entry whose parameter is below the query t and returns
// one response: entry 0 with status 1 when t is at or below the first
// parameter, the last entry in use with status 2 when t is beyond it, zeros
// with status 3 when point_count is 0, and otherwise the interpolation
// y0 + (y1-y0)*(t-t0)/(t1-t0), truncated toward zero, with status 0. The
// table is one RAM with registered read, and a query makes S = ceil(log2(n+1))
// search steps, at most 7 for 64 entries, each a read of the probe entry and a
// narrowing of the range. An interpolating query then runs the two bit-serial
// lanes (x and y run together): they form b-a and a-b, then do a combined
// multiply and divide one numerator bit per cycle, then the final add.
// One query is in flight at a time; the response register lets the next
// request be taken while a response waits on rsp_stall. Table contents are
// not cleared by reset and must be loaded before they are queried.
// point_count is written through the csr channel; the user must write it only
// while the unit is idle, as the block itself does not enforce this; values
// above TABLE_DEPTH act as TABLE_DEPTH.
`default_nettype none

module curve_param_lookup_interp_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic        [cpli_pkg::INDEX_W-1:0] req_entry_index,
   input  wire logic        [cpli_pkg::PARAM_W-1:0] req_param_value,
   input  wire logic signed [cpli_pkg::COORD_W-1:0] req_point_x,
   input  wire logic signed [cpli_pkg::COORD_W-1:0] req_point_y,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [cpli_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed      [cpli_pkg::COORD_W-1:0] rsp_out_y,
   output logic             [1:0]                   rsp_status,
   // point count register
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [cpli_pkg::CFG_W-1:0]   csr_point_count
);

   localparam int PW    = cpli_pkg::PARAM_W;
   localparam int CW    = cpli_pkg::COORD_W;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int POS_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (POS_W > cpli_pkg::CFG_W) ? POS_W : cpli_pkg::CFG_W;
   localparam int EW    = (POS_W > cpli_pkg::INDEX_W) ? POS_W : cpli_pkg::INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,     // issue probe read, or read of the result entries
      ST_SWAIT,      // probe data back, narrow the range
      ST_FETCH_ONE,  // clamped result entry back
      ST_FETCH_A,    // lower entry back, read upper
      ST_FETCH_B,    // upper entry back, start lanes
      ST_LERP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [cpli_pkg::CFG_W-1:0] point_count_ff, point_count_in;
   logic [PW-1:0]    t_ff, t_in, t0_ff, t0_in;
   logic [POS_W-1:0] n_ff, n_in, low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic [CW-1:0]    xa_ff, xa_in, ya_ff, ya_in;
   logic [CW-1:0]    res_x_ff, res_x_in, res_y_ff, res_y_in;
   cpli_pkg::status_type status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   cpli_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                   req_accept, rsp_take, load_en, search_done;
   logic [CMP_W-1:0]       count_ext;
   logic [POS_W-1:0]       n_c, mid_c;
   logic [POS_W:0]         mid_sum;
   logic [IDX_W-1:0]       rd_addr;
   logic [$bits(cpli_pkg::entry_type)-1:0] rd_data;
   cpli_pkg::entry_type    rd_entry, wr_entry;
   cpli_pkg::lane_ctl_type lane_ctl;
   logic [CW-1:0]          lane_res_x, lane_res_y;
   logic                   lane_done_x, lane_done_y;

   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign load_en    = req_accept && (req_command == cpli_pkg::CMD_LOAD) &&
                       (EW'(req_entry_index) < EW'(TABLE_DEPTH));

   assign wr_entry = '{param: req_param_value, x: req_point_x, y: req_point_y};
   assign rd_entry = rd_data;

   // entries in use, capped at the table depth
   assign count_ext = CMP_W'(point_count_ff);
   assign n_c = (count_ext > CMP_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH) : POS_W'(count_ext);

   assign mid_sum     = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_c       = POS_W'(mid_sum >> 1);
   assign search_done = !(low_ff < high_ff);

   // read address for the next cycle's data
   always_comb begin
      rd_addr = '0;
      case (state_ff)
         ST_SEARCH: begin
            if (!search_done) begin
               rd_addr = IDX_W'(mid_c);
            end else if (low_ff == '0) begin
               rd_addr = '0;
            end else if (low_ff >= n_ff) begin
               rd_addr = IDX_W'(n_ff - POS_W'(1));
            end else begin
               rd_addr = IDX_W'(low_ff - POS_W'(1));
            end
         end
         ST_FETCH_A: rd_addr = IDX_W'(low_ff);
         default:    rd_addr = '0;
      endcase
   end

   assign lane_ctl.start = (state_ff == ST_FETCH_B);
   assign lane_ctl.dt    = t_ff - t0_ff;
   assign lane_ctl.span  = rd_entry.param - t0_ff;

   always_comb begin
      state_in       = state_ff;
      point_count_in = csr_valid ? csr_point_count : point_count_ff;
      t_in           = t_ff;
      t0_in          = t0_ff;
      n_in           = n_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      mid_in         = mid_ff;
      xa_in          = xa_ff;
      ya_in          = ya_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_status_in  = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command == cpli_pkg::CMD_QUERY)) begin
               t_in    = req_param_value;
               n_in    = n_c;
               low_in  = '0;
               high_in = n_c;
               if (n_c == '0) begin
                  res_x_in  = '0;
                  res_y_in  = '0;
                  status_in = cpli_pkg::STATUS_EMPTY;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (!search_done) begin
               mid_in   = mid_c;
               state_in = ST_SWAIT;
            end else if (low_ff == '0) begin
               status_in = cpli_pkg::STATUS_FIRST;
               state_in  = ST_FETCH_ONE;
            end else if (low_ff >= n_ff) begin
               status_in = cpli_pkg::STATUS_LAST;
               state_in  = ST_FETCH_ONE;
            end else begin
               state_in = ST_FETCH_A;
            end
         end
         ST_SWAIT: begin
            if (rd_entry.param < t_ff) begin
               low_in = mid_ff + POS_W'(1);
            end else begin
               high_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end
         ST_FETCH_ONE: begin
            res_x_in = rd_entry.x;
            res_y_in = rd_entry.y;
            state_in = ST_FINISH;
         end
         ST_FETCH_A: begin
            t0_in    = rd_entry.param;
            xa_in    = rd_entry.x;
            ya_in    = rd_entry.y;
            state_in = ST_FETCH_B;
         end
         ST_FETCH_B: begin
            status_in = cpli_pkg::STATUS_INTERP;
            state_in  = ST_LERP;
         end
         ST_LERP: begin
            if (lane_done_x && lane_done_y) begin
               res_x_in = lane_res_x;
               res_y_in = lane_res_y;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // response register free, or emptied this cycle
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      t0_ff         <= t0_in;
      n_ff          <= n_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      mid_ff        <= mid_in;
      xa_ff         <= xa_in;
      ya_ff         <= ya_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      status_ff     <= status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_status = rsp_status_ff;

   cpli_ram #(
      .WIDTH ($bits(cpli_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // x and y lanes run in lockstep off the same start
   cpli_lane u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .coord_a (xa_ff),
      .coord_b (rd_entry.x),
      .result  (lane_res_x),
      .done    (lane_done_x)
   );

   cpli_lane u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .coord_a (ya_ff),
      .coord_b (rd_entry.y),
      .result  (lane_res_y),
      .done    (lane_done_y)
   );

`ifndef ASSERT_OFF
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_done_x == lane_done_y)
      else $error("interpolation lanes out of step");

   a_done_in_lerp: assert property (@(posedge clock) disable iff (reset)
      lane_done_x |-> (state_ff == ST_LERP))
      else $error("lane finished outside interpolation wait");

   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWAIT) |->
         (low_ff <= mid_ff && mid_ff < high_ff && high_ff <= n_ff))
      else $error("search probe outside its range");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished query not moved to response register");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for curve_param_lookup_interp_unit: table loads, point lookups, clamping, interpolation.

module tb;

   localparam int DEPTH          = 64;
   // Idle time after the drain; allow some margin on top of a query's run.
   localparam int QUIET_CYCLES   = 150;
   // Watchdog limit, kept well clear of the slowest legal run.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [cpli_pkg::PARAM_W-1:0] PARAM_TOP = '1;

   typedef struct {
      logic [cpli_pkg::COORD_W-1:0] x;
      logic [cpli_pkg::COORD_W-1:0] y;
      cpli_pkg::status_type         status;
   } point_result_type;

   // ------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic                          req_command     = cpli_pkg::CMD_LOAD;
   logic [cpli_pkg::INDEX_W-1:0]  req_entry_index = '0;
   logic [cpli_pkg::PARAM_W-1:0]  req_param_value = '0;
   logic [cpli_pkg::COORD_W-1:0]  req_point_x     = '0;
   logic [cpli_pkg::COORD_W-1:0]  req_point_y     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic [cpli_pkg::COORD_W-1:0]  rsp_out_x;
   logic [cpli_pkg::COORD_W-1:0]  rsp_out_y;
   logic [1:0]                    rsp_status;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [cpli_pkg::CFG_W-1:0]    csr_point_count = '0;

   curve_param_lookup_interp_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_param_value (req_param_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_point_count (csr_point_count)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the curve table and point count
   // ------------------------------------------------------------------
   logic [cpli_pkg::PARAM_W-1:0] curve_param [DEPTH];
   logic [cpli_pkg::COORD_W-1:0] curve_x     [DEPTH];
   logic [cpli_pkg::COORD_W-1:0] curve_y     [DEPTH];
   logic [cpli_pkg::CFG_W-1:0]   active_count = '0;

   point_result_type expected_points[$];   // one entry per accepted query, oldest first
   int               error_count = 0;
   int               idle_pct    = 0;      // sender gap chance per request, percent
   int               stall_pct   = 0;      // receiver stall chance per cycle, percent
   int unsigned      cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // y0 + (y1-y0)*dt/span, quotient truncated toward zero (SV signed divide does that)
   function automatic logic [cpli_pkg::COORD_W-1:0] interp_coord(
         input logic signed [cpli_pkg::COORD_W-1:0] a,
         input logic signed [cpli_pkg::COORD_W-1:0] b,
         input longint dt, input longint span);
      longint base;
      longint delta;
      base  = a;
      delta = longint'(b) - base;
      return cpli_pkg::COORD_W'(base + (delta * dt) / span);
   endfunction

   // Binary search for the last entry strictly below t, then clamp or interpolate.
   function automatic void predict_lookup(input logic [cpli_pkg::PARAM_W-1:0] t);
      int               n;
      int               lo;
      int               hi;
      int               mid;
      longint           dt;
      longint           span;
      point_result_type res;
      n   = (active_count > DEPTH) ? DEPTH : int'(active_count);
      res = '{'0, '0, cpli_pkg::STATUS_EMPTY};
      if (n > 0) begin
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (curve_param[mid] < t) lo = mid + 1;
            else hi = mid;
         end
         if (lo == 0) begin
            res = '{curve_x[0], curve_y[0], cpli_pkg::STATUS_FIRST};
         end else if (lo >= n) begin
            res = '{curve_x[n-1], curve_y[n-1], cpli_pkg::STATUS_LAST};
         end else begin
            // search guarantees t0 < t <= t1, so span is never zero
            dt         = longint'(t) - longint'(curve_param[lo-1]);
            span       = longint'(curve_param[lo]) - longint'(curve_param[lo-1]);
            res.x      = interp_coord(curve_x[lo-1], curve_x[lo], dt, span);
            res.y      = interp_coord(curve_y[lo-1], curve_y[lo], dt, span);
            res.status = cpli_pkg::STATUS_INTERP;
         end
      end
      expected_points.push_back(res);
   endfunction

   // Mostly random words, with the corners of the Q16.16 range mixed in.
   function automatic logic [cpli_pkg::COORD_W-1:0] random_coord();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Query t aimed at the interesting spots of the first `used` entries.
   function automatic logic [cpli_pkg::PARAM_W-1:0] pick_query_param(input int used);
      int k;
      int k2;
      if (used == 0) return cpli_pkg::PARAM_W'($urandom_range(0, 131071));
      k  = $urandom_range(0, used - 1);
      k2 = (k + 1 < used) ? k + 1 : k;
      case ($urandom_range(0, 7))
         0:       return curve_param[k];
         1:       return curve_param[k] + 1'b1;
         2:       return curve_param[k] - 1'b1;
         3:       return cpli_pkg::PARAM_W'($urandom_range(0, 65536));
         4:       return cpli_pkg::PARAM_W'($urandom_range(0, 131071));
         5:       return $urandom_range(0, 1) ? PARAM_TOP : '0;
         default: return cpli_pkg::PARAM_W'($urandom_range(curve_param[k], curve_param[k2]));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Returns right after the accepting edge with valid
   // still high, so a following request goes out back to back.
   // ------------------------------------------------------------------
   task automatic send_request(input logic cmd, input logic [cpli_pkg::INDEX_W-1:0] idx,
                               input logic [cpli_pkg::PARAM_W-1:0] t,
                               input logic [cpli_pkg::COORD_W-1:0] px,
                               input logic [cpli_pkg::COORD_W-1:0] py);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_entry_index <= idx;
      req_param_value <= t;
      req_point_x     <= px;
      req_point_y     <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: update the shadow table or queue the answer
      if (cmd == cpli_pkg::CMD_LOAD) begin
         curve_param[idx] = t;
         curve_x[idx]     = px;
         curve_y[idx]     = py;
      end else begin
         predict_lookup(t);
      end
   endtask

   // Unused fields of a query carry random bits; the block must ignore them.
   task automatic send_query(input logic [cpli_pkg::PARAM_W-1:0] t);
      send_request(cpli_pkg::CMD_QUERY, cpli_pkg::INDEX_W'($urandom), t, $urandom, $urandom);
   endtask

   // Drop valid, let every outstanding response drain, then let the unit settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Point count is only changed with the unit idle.
   task automatic write_point_count(input logic [cpli_pkg::CFG_W-1:0] n);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_point_count <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      active_count  = n;
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------
   task automatic test_empty_table();
      // count is zero out of reset
      send_query('0);
      send_query(PARAM_TOP);
   endtask

   task automatic test_clamp_and_interp();
      // coordinate extremes so the deltas span the full 33-bit range
      send_request(cpli_pkg::CMD_LOAD, 6'd0, 17'h01000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(cpli_pkg::CMD_LOAD, 6'd1, 17'h04000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(cpli_pkg::CMD_LOAD, 6'd2, 17'h08000, 32'h0001_0000, 32'hFFFF_0000);
      send_request(cpli_pkg::CMD_LOAD, 6'd3, 17'h10000, 32'hFFFF_FFFF, 32'h0000_0001);
      write_point_count(7'd4);
      send_query(17'h00000);    // below first
      send_query(17'h01000);    // equal to first still clamps
      send_query(17'h01001);    // one step in, negative y product truncates toward zero
      send_query(17'h02800);
      send_query(17'h04000);    // exactly on an inner entry
      send_query(17'h0C000);
      send_query(17'h10000);    // exactly on the last entry, still interpolated
      send_query(17'h10001);    // just past the end
      send_query(PARAM_TOP);
   endtask

   task automatic test_single_point();
      write_point_count(7'd1);
      send_query(17'h00000);
      send_query(17'h01000);
      send_query(PARAM_TOP);
   endtask

   task automatic test_duplicate_and_unordered();
      // entry 2 gets the same parameter as entry 1
      send_request(cpli_pkg::CMD_LOAD, 6'd2, 17'h04000, random_coord(), random_coord());
      write_point_count(7'd4);
      send_query(17'h04000);
      send_query(17'h04001);
      // entry 1 above 1.0 breaks the ordering; the search still brackets t
      send_request(cpli_pkg::CMD_LOAD, 6'd1, PARAM_TOP, random_coord(), random_coord());
      send_query(17'h09000);
      send_query(17'h00800);
   endtask

   // ------------------------------------------------------------------
   // Random traffic: fresh table per phase, then mixed lookups and reloads
   // ------------------------------------------------------------------
   task automatic run_phase(input int idle, input int stall,
                            input logic [cpli_pkg::CFG_W-1:0] n, input int items);
      int                           used;
      int                           step_max;
      int                           idx;
      logic [cpli_pkg::PARAM_W-1:0] level;
      logic [cpli_pkg::PARAM_W-1:0] t;
      idle_pct  = idle;
      stall_pct = stall;
      write_point_count(n);
      used     = (n > DEPTH) ? DEPTH : int'(n);
      // mostly nondecreasing tables; some steep, some nearly flat, a few scrambled
      case ($urandom_range(0, 9))
         0, 1, 2, 3: step_max = 1024;
         4, 5:       step_max = 4096;
         6, 7:       step_max = 3;
         default:    step_max = -1;
      endcase
      level = cpli_pkg::PARAM_W'($urandom_range(0, 1024));
      for (int i = 0; i < used; i++) begin
         if (step_max < 0) begin
            t = cpli_pkg::PARAM_W'($urandom_range(0, 131071));
         end else begin
            t     = level;
            level = (int'(level) + step_max >= 131071) ? PARAM_TOP
                  : level + cpli_pkg::PARAM_W'($urandom_range(0, step_max));
         end
         send_request(cpli_pkg::CMD_LOAD, cpli_pkg::INDEX_W'(i), t,
                      random_coord(), random_coord());
      end
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 70) begin
            send_query(pick_query_param(used));
         end else begin
            idx = $urandom_range(0, DEPTH - 1);
            // keep the parameter most of the time so the order survives
            t   = ($urandom_range(9) < 8) ? curve_param[idx]
                                          : cpli_pkg::PARAM_W'($urandom_range(0, 131071));
            send_request(cpli_pkg::CMD_LOAD, cpli_pkg::INDEX_W'(idx), t,
                         random_coord(), random_coord());
         end
      end
   endtask

   task automatic test_random_traffic();
      run_phase( 0,  0, 7'd64,  130);
      run_phase(69,  0, 7'd127, 130);
      run_phase( 0, 69, 7'd1,   130);
      run_phase(11, 11, 7'd2,   130);
      run_phase( 0, 69, 7'd0,   130);
      run_phase( 0,  0, 7'd33,  130);
      run_phase(69,  0, 7'd65,  130);
      run_phase(11, 11, 7'd64,  130);
      run_phase(69,  0, 7'd7,   130);
      run_phase( 0, 69, 7'd100, 130);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, and response check against the oldest entry
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_response
      point_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_points.size() == 0) begin
            $error("response with no query outstanding: out_x %0h out_y %0h status %0d",
                   rsp_out_x, rsp_out_y, rsp_status);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_out_x !== want.x) begin
               $error("out_x: expected %0h, got %0h", want.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y: expected %0h, got %0h", want.y, rsp_out_y);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         curve_param[i] = '0;
         curve_x[i]     = '0;
         curve_y[i]     = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_clamp_and_interp();
      test_single_point();
      test_duplicate_and_unordered();
      test_random_traffic();
      wait_drained();
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
